// ----- src/octree_node_address_unit_top_assert.svh -----
// Assertion macros for the octree node address unit.
// Included by octree_node_address_unit_top.sv; expects clk and rst in scope.
`ifndef OCTREE_NODE_ADDRESS_UNIT_TOP_ASSERT_SVH
`define OCTREE_NODE_ADDRESS_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define ONAU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define ONAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/onau_pkg.sv -----
// Shared constants and the command encoding of the octree node address unit.
// No dependencies.
package onau_pkg;

  localparam int COORD_BITS = 16;
  localparam int MAX_LEVEL  = 15;
  localparam int LEVEL_W    = 4;
  localparam int CMD_W      = 3;
  localparam int OCT_W      = 3;
  localparam int AXES       = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PARENT    = 3'd0,
    CMD_CHILD     = 3'd1,
    CMD_OCTANT    = 3'd2,
    CMD_ROOT      = 3'd3,
    CMD_CONTAINER = 3'd4,
    CMD_CONTAINS  = 3'd5,
    CMD_IS_ROOT   = 3'd6
  } cmd_t;

endpackage

// ----- src/octree_node_address_unit_top.sv -----
// Octree node address unit: four-stage pipelined address arithmetic on cubic nodes.
// Depends on onau_pkg and octree_node_address_unit_top_assert.svh.
//
// Usage:
// One input channel (in_valid / in_stall) carries an item: a command, two nodes a and b
// (signed minimum corner plus edge exponent) and an octant selector for the child command.
// One output channel (out_valid / out_stall) returns exactly one result item per input
// item, in order: a result node, an octant answer, a flag and an error bit. Fields that a
// command does not produce are zero, and every field but error is zero on an error.
// An item is accepted on a rising edge with valid high and stall low.
// A result passes through stages A, B and C and the output register. The block takes
// one item per cycle while out_stall is low: each of the four register stages advances
// whenever the stage after it is empty or moving.
// Stage A extends the corners and forms the node ends, floors and child sums. Stage B
// does the containment compares, the octant midpoints and the folded difference words.
// Stage C runs the leading-one counts that give the container and root levels, and the
// octant compares. The output register selects the result for the command.
// When the receiver holds out_stall, the result stays in the output register, the stages
// behind it fill up, and in_stall rises only once all four stages hold an item.
// Synchronous reset empties the pipeline; no item is in flight after it.
`include "octree_node_address_unit_top_assert.svh"

module octree_node_address_unit_top #(
  parameter int COORD_BITS = onau_pkg::COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [onau_pkg::CMD_W-1:0]        command,
  input  logic signed [COORD_BITS-1:0]      a_x,
  input  logic signed [COORD_BITS-1:0]      a_y,
  input  logic signed [COORD_BITS-1:0]      a_z,
  input  logic [onau_pkg::LEVEL_W-1:0]      a_level,
  input  logic signed [COORD_BITS-1:0]      b_x,
  input  logic signed [COORD_BITS-1:0]      b_y,
  input  logic signed [COORD_BITS-1:0]      b_z,
  input  logic [onau_pkg::LEVEL_W-1:0]      b_level,
  input  logic [onau_pkg::OCT_W-1:0]        child_octant,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COORD_BITS-1:0]      res_x,
  output logic signed [COORD_BITS-1:0]      res_y,
  output logic signed [COORD_BITS-1:0]      res_z,
  output logic [onau_pkg::LEVEL_W-1:0]      res_level,
  output logic [onau_pkg::OCT_W-1:0]        octant_out,
  output logic                              octant_valid,
  output logic                              flag,
  output logic                              error
);

  localparam int AXES = onau_pkg::AXES;
  // The largest edge in use is 2^(2^LEVEL_W), the parent of the top level; two guard
  // bits keep ends and sums of signed corners exact.
  localparam int SPAN = 2 ** onau_pkg::LEVEL_W;
  localparam int EW   = ((COORD_BITS > SPAN) ? COORD_BITS : SPAN) + 2;
  localparam int LW   = $clog2(EW + 2);

  typedef logic signed [EW-1:0]         ext_t;
  typedef logic signed [COORD_BITS-1:0] crd_t;

  function automatic ext_t sext(input logic [COORD_BITS-1:0] v);
    sext = {{(EW - COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic ext_t pow2(input logic [LW-1:0] k);
    pow2 = ext_t'(1) << k;
  endfunction

  function automatic ext_t low_mask(input logic [LW-1:0] k);
    low_mask = pow2(k) - ext_t'(1);
  endfunction

  // Position of the highest set bit plus one; zero for an all-zero word.
  function automatic logic [LW-1:0] bit_len(input logic [EW-1:0] v);
    bit_len = '0;
    for (int i = 0; i < EW; i++) begin
      if (v[i]) begin
        bit_len = LW'(i + 1);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Flow control: each stage advances when it is empty or the next one advances.
  // ---------------------------------------------------------------------------------------
  logic en_a, en_b, en_c, en_d;
  logic sa_valid, sb_valid, sc_valid;

  assign en_d     = !out_valid || !out_stall;
  assign en_c     = !sc_valid || en_d;
  assign en_b     = !sb_valid || en_c;
  assign en_a     = !sa_valid || en_b;
  assign in_stall = !en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid  <= 1'b0;
      sb_valid  <= 1'b0;
      sc_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) begin
        sa_valid <= in_valid;
      end
      if (en_b) begin
        sb_valid <= sa_valid;
      end
      if (en_c) begin
        sc_valid <= sb_valid;
      end
      if (en_d) begin
        out_valid <= sc_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage A: sign extension, node ends, parent floor and child corner.
  // ---------------------------------------------------------------------------------------
  ext_t           a_in [AXES];
  ext_t           b_in [AXES];
  logic [LW-1:0]  a_lv_in, b_lv_in;

  assign a_in[0] = sext(a_x);
  assign a_in[1] = sext(a_y);
  assign a_in[2] = sext(a_z);
  assign b_in[0] = sext(b_x);
  assign b_in[1] = sext(b_y);
  assign b_in[2] = sext(b_z);
  assign a_lv_in = LW'(a_level);
  assign b_lv_in = LW'(b_level);

  ext_t a_hi_next   [AXES];
  ext_t a_last_next [AXES];
  ext_t b_last_next [AXES];
  ext_t p_lo_next   [AXES];
  ext_t child_sum   [AXES];

  // The last cell of a node is corner + 2^level - 1; the parent corner is the corner
  // with the low level+1 bits cleared, which is a floor for negative corners too.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      a_hi_next[i]   = a_in[i] + pow2(a_lv_in);
      a_last_next[i] = a_in[i] + low_mask(a_lv_in);
      b_last_next[i] = b_in[i] + low_mask(b_lv_in);
      p_lo_next[i]   = a_in[i] & ~low_mask(a_lv_in + LW'(1));
      child_sum[i]   = a_in[i] + (child_octant[i] ? pow2(a_lv_in - LW'(1)) : '0);
    end
  end

  onau_pkg::cmd_t sa_cmd;
  logic [LW-1:0]  sa_a_lv, sa_b_lv;
  ext_t           sa_a      [AXES];
  ext_t           sa_b      [AXES];
  ext_t           sa_a_hi   [AXES];
  ext_t           sa_a_last [AXES];
  ext_t           sa_b_last [AXES];
  ext_t           sa_p_lo   [AXES];
  crd_t           sa_child  [AXES];

  always_ff @(posedge clk) begin
    if (en_a) begin
      sa_cmd  <= onau_pkg::cmd_t'(command);
      sa_a_lv <= a_lv_in;
      sa_b_lv <= b_lv_in;
      for (int i = 0; i < AXES; i++) begin
        sa_a[i]      <= a_in[i];
        sa_b[i]      <= b_in[i];
        sa_a_hi[i]   <= a_hi_next[i];
        sa_a_last[i] <= a_last_next[i];
        sa_b_last[i] <= b_last_next[i];
        sa_p_lo[i]   <= p_lo_next[i];
        sa_child[i]  <= child_sum[i][COORD_BITS-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage B: containment both ways, centred-cube test, octant midpoints, and the folded
  // words whose bit length gives the container and root levels.
  // ---------------------------------------------------------------------------------------
  logic          hold_ab_next, hold_ba_next, sign_err_next, is_root_next;
  logic [EW-1:0] d_next, v_next;
  ext_t          mid_next [AXES];

  // A node at level k holds b exactly when b's first and last cells agree with a's
  // corner above bit k-1, so the smallest ancestor level is the bit length of the OR
  // of those differences. For the root, max(|lo|,|hi|) - 1 of an aligned cell is lo
  // with its low bits set, or ~lo for a negative cell; the bit length of the OR over
  // the axes equals that of the maximum.
  always_comb begin
    ext_t rnd_hi;
    ext_t rnd_lo;
    hold_ab_next  = 1'b1;
    hold_ba_next  = 1'b1;
    sign_err_next = 1'b0;
    is_root_next  = 1'b1;
    d_next        = '0;
    v_next        = '0;
    rnd_hi        = '0;
    rnd_lo        = '0;
    for (int i = 0; i < AXES; i++) begin
      if (sa_b[i] < sa_a[i] || sa_b_last[i] > sa_a_last[i]) begin
        hold_ab_next = 1'b0;
      end
      if (sa_a[i] < sa_b[i] || sa_a_last[i] > sa_b_last[i]) begin
        hold_ba_next = 1'b0;
      end
      if (sa_a[i][EW-1] != sa_b[i][EW-1]) begin
        sign_err_next = 1'b1;
      end
      if (sa_a[i] + sa_a_hi[i] != '0) begin
        is_root_next = 1'b0;
      end
      d_next = d_next | (sa_a[i] ^ sa_b[i]) | (sa_a[i] ^ sa_b_last[i]);
      v_next = v_next | (sa_p_lo[i][EW-1] ? ~sa_p_lo[i]
                                          : (sa_p_lo[i] | low_mask(sa_a_lv + LW'(1))));
      // Halves round toward zero: an odd negative value takes one back after the shift.
      rnd_hi[0]   = sa_a_hi[i][EW-1] & sa_a_hi[i][0];
      rnd_lo[0]   = sa_a[i][EW-1] & sa_a[i][0];
      mid_next[i] = (sa_a_hi[i] >>> 1) + (sa_a[i] >>> 1) + rnd_hi + rnd_lo;
    end
  end

  onau_pkg::cmd_t sb_cmd;
  logic [LW-1:0]  sb_a_lv, sb_b_lv;
  logic           sb_hold_ab, sb_hold_ba, sb_sign_err, sb_is_root;
  logic [EW-1:0]  sb_d, sb_v;
  ext_t           sb_mid    [AXES];
  ext_t           sb_b      [AXES];
  ext_t           sb_b_last [AXES];
  crd_t           sb_a_w    [AXES];
  crd_t           sb_parent [AXES];
  crd_t           sb_child  [AXES];

  always_ff @(posedge clk) begin
    if (en_b) begin
      sb_cmd      <= sa_cmd;
      sb_a_lv     <= sa_a_lv;
      sb_b_lv     <= sa_b_lv;
      sb_hold_ab  <= hold_ab_next;
      sb_hold_ba  <= hold_ba_next;
      sb_sign_err <= sign_err_next;
      sb_is_root  <= is_root_next;
      sb_d        <= d_next;
      sb_v        <= v_next;
      for (int i = 0; i < AXES; i++) begin
        sb_mid[i]    <= mid_next[i];
        sb_b[i]      <= sa_b[i];
        sb_b_last[i] <= sa_b_last[i];
        sb_a_w[i]    <= sa_a[i][COORD_BITS-1:0];
        sb_parent[i] <= sa_p_lo[i][COORD_BITS-1:0];
        sb_child[i]  <= sa_child[i];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage C: leading-one counts for the container and root levels, octant compares.
  // ---------------------------------------------------------------------------------------
  logic [LW-1:0]   cont_lv_next, root_s_next;
  logic [AXES-1:0] oct_bits_next;
  logic            oct_ok_next;

  always_comb begin
    logic [LW-1:0]   lv_floor;
    logic [LW-1:0]   d_len;
    logic [AXES-1:0] straddle;
    lv_floor     = sb_a_lv + LW'(1);
    d_len        = bit_len(sb_d);
    cont_lv_next = (d_len > lv_floor) ? d_len : lv_floor;
    root_s_next  = bit_len(sb_v) + LW'(1);
    for (int i = 0; i < AXES; i++) begin
      // b ends past the midpoint when its last cell is at or above it.
      oct_bits_next[i] = sb_b_last[i] >= sb_mid[i];
      straddle[i]      = (sb_b[i] < sb_mid[i]) && (sb_b_last[i] >= sb_mid[i]);
    end
    oct_ok_next = ~|straddle;
  end

  onau_pkg::cmd_t  sc_cmd;
  logic [LW-1:0]   sc_a_lv, sc_b_lv, sc_cont_lv, sc_root_s;
  logic            sc_hold_ab, sc_hold_ba, sc_sign_err, sc_is_root, sc_oct_ok;
  logic [AXES-1:0] sc_oct_bits;
  crd_t            sc_a_w    [AXES];
  crd_t            sc_b_w    [AXES];
  crd_t            sc_parent [AXES];
  crd_t            sc_child  [AXES];

  always_ff @(posedge clk) begin
    if (en_c) begin
      sc_cmd      <= sb_cmd;
      sc_a_lv     <= sb_a_lv;
      sc_b_lv     <= sb_b_lv;
      sc_cont_lv  <= cont_lv_next;
      sc_root_s   <= root_s_next;
      sc_hold_ab  <= sb_hold_ab;
      sc_hold_ba  <= sb_hold_ba;
      sc_sign_err <= sb_sign_err;
      sc_is_root  <= sb_is_root;
      sc_oct_ok   <= oct_ok_next;
      sc_oct_bits <= oct_bits_next;
      for (int i = 0; i < AXES; i++) begin
        sc_a_w[i]    <= sb_a_w[i];
        sc_b_w[i]    <= sb_b[i][COORD_BITS-1:0];
        sc_parent[i] <= sb_parent[i];
        sc_child[i]  <= sb_child[i];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Output stage: pick the result for the command. Defaults are zero, and an error
  // branch sets only the error bit, so an error item carries an all-zero payload.
  // ---------------------------------------------------------------------------------------
  crd_t                         res_next [AXES];
  logic [LW-1:0]                lv_next;
  logic [onau_pkg::OCT_W-1:0]   oct_next;
  logic                         ovalid_next, flag_next, err_next;

  always_comb begin
    ext_t root_c;
    ext_t cont_mask;
    root_c      = -pow2(sc_root_s - LW'(1));
    cont_mask   = low_mask(sc_cont_lv);
    lv_next     = '0;
    oct_next    = '0;
    ovalid_next = 1'b0;
    flag_next   = 1'b0;
    err_next    = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      res_next[i] = '0;
    end
    case (sc_cmd)
      onau_pkg::CMD_PARENT: begin
        if (sc_a_lv >= LW'(onau_pkg::MAX_LEVEL)) begin
          err_next = 1'b1;
        end else begin
          for (int i = 0; i < AXES; i++) begin
            res_next[i] = sc_parent[i];
          end
          lv_next = sc_a_lv + LW'(1);
        end
      end
      onau_pkg::CMD_CHILD: begin
        if (sc_a_lv == '0) begin
          err_next = 1'b1;
        end else begin
          for (int i = 0; i < AXES; i++) begin
            res_next[i] = sc_child[i];
          end
          lv_next = sc_a_lv - LW'(1);
        end
      end
      onau_pkg::CMD_OCTANT: begin
        if (!sc_hold_ab) begin
          err_next = 1'b1;
        end else if (sc_a_lv != '0 && sc_oct_ok) begin
          ovalid_next = 1'b1;
          oct_next    = sc_oct_bits;
        end
      end
      onau_pkg::CMD_ROOT: begin
        if (sc_root_s > LW'(onau_pkg::MAX_LEVEL) || sc_root_s > LW'(COORD_BITS)) begin
          err_next = 1'b1;
        end else begin
          for (int i = 0; i < AXES; i++) begin
            res_next[i] = root_c[COORD_BITS-1:0];
          end
          lv_next = sc_root_s;
        end
      end
      onau_pkg::CMD_CONTAINER: begin
        if (sc_sign_err) begin
          err_next = 1'b1;
        end else if (sc_hold_ab) begin
          for (int i = 0; i < AXES; i++) begin
            res_next[i] = sc_a_w[i];
          end
          lv_next = sc_a_lv;
        end else if (sc_hold_ba) begin
          for (int i = 0; i < AXES; i++) begin
            res_next[i] = sc_b_w[i];
          end
          lv_next = sc_b_lv;
        end else if (sc_cont_lv > LW'(onau_pkg::MAX_LEVEL)) begin
          err_next = 1'b1;
        end else begin
          for (int i = 0; i < AXES; i++) begin
            res_next[i] = sc_a_w[i] & ~cont_mask[COORD_BITS-1:0];
          end
          lv_next = sc_cont_lv;
        end
      end
      onau_pkg::CMD_CONTAINS: begin
        flag_next = sc_hold_ab;
      end
      onau_pkg::CMD_IS_ROOT: begin
        flag_next = sc_is_root;
      end
      default: begin
        err_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      res_x        <= res_next[0];
      res_y        <= res_next[1];
      res_z        <= res_next[2];
      res_level    <= lv_next[onau_pkg::LEVEL_W-1:0];
      octant_out   <= oct_next;
      octant_valid <= ovalid_next;
      flag         <= flag_next;
      error        <= err_next;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  logic                            err_out, oct_out, oct_alone, payload_zero;
  logic                            pipe_full, b_blocked;
  logic [onau_pkg::CMD_W+2*EW-1:0] sb_word;

  assign err_out      = out_valid && error;
  assign oct_out      = out_valid && octant_valid;
  assign oct_alone    = !error && !flag && res_level == '0;
  assign payload_zero = res_x == '0 && res_y == '0 && res_z == '0 && res_level == '0 &&
                        octant_out == '0 && !octant_valid && !flag;
  assign pipe_full    = sa_valid && sb_valid && sc_valid && out_valid && out_stall;
  assign b_blocked    = sb_valid && !en_b;
  assign sb_word      = {sb_cmd, sb_d, sb_v};

  `ONAU_ASSERT_NOW(a_err_clears_payload, err_out, payload_zero, "error result with a payload")
  `ONAU_ASSERT_NOW(a_octant_exclusive, oct_out, oct_alone, "octant answer with other results")
  `ONAU_ASSERT_NOW(a_stall_only_when_full, in_stall, pipe_full, "input stalled with a bubble")
  `ONAU_ASSERT_NEXT(a_stage_b_holds, b_blocked, sb_valid && $stable(sb_word), "stage B changed")

endmodule

// ----- tb/octree_node_address_unit_top_tb.sv -----
// Self-checking testbench for the octree node address unit: directed corner cases, then
// random queries, with a behavioral predictor and randomized idling on both channels.
// Depends on onau_pkg and octree_node_address_unit_top.
module octree_node_address_unit_top_tb;
  import onau_pkg::*;

  // The command field is three bits wide, so one encoding is left without an operation.
  localparam logic [CMD_W-1:0] CMD_UNDEFINED = 3'd7;

  // One item on the input channel: the command, node a, node b and the child octant.
  typedef struct {
    logic [CMD_W-1:0]               command;
    logic signed [COORD_BITS-1:0]   a [AXES];
    logic [LEVEL_W-1:0]             a_level;
    logic signed [COORD_BITS-1:0]   b [AXES];
    logic [LEVEL_W-1:0]             b_level;
    logic [OCT_W-1:0]               octant;
  } node_query_t;

  // One item on the output channel.
  typedef struct {
    logic signed [COORD_BITS-1:0]   pos [AXES];
    logic [LEVEL_W-1:0]             level;
    logic [OCT_W-1:0]               octant;
    logic                           octant_ok;
    logic                           flag;
    logic                           error;
  } node_answer_t;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HOLD} stall_mode_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [CMD_W-1:0]               command = '0;
  logic signed [COORD_BITS-1:0]   a_x = '0;
  logic signed [COORD_BITS-1:0]   a_y = '0;
  logic signed [COORD_BITS-1:0]   a_z = '0;
  logic [LEVEL_W-1:0]             a_level = '0;
  logic signed [COORD_BITS-1:0]   b_x = '0;
  logic signed [COORD_BITS-1:0]   b_y = '0;
  logic signed [COORD_BITS-1:0]   b_z = '0;
  logic [LEVEL_W-1:0]             b_level = '0;
  logic [OCT_W-1:0]               child_octant = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [COORD_BITS-1:0]   res_x;
  logic signed [COORD_BITS-1:0]   res_y;
  logic signed [COORD_BITS-1:0]   res_z;
  logic [LEVEL_W-1:0]             res_level;
  logic [OCT_W-1:0]               octant_out;
  logic                           octant_valid;
  logic                           flag;
  logic                           error;

  node_query_t  query_q [$];   // items not yet offered to the block
  node_answer_t answer_q [$];  // expected results of accepted items, oldest first
  int           mismatches = 0;
  logic         in_taken = 1'b0;
  int           gap_left = 0;
  int           burst_left = 1;
  stall_mode_t  stall_mode = STALL_NONE;
  int           stall_tick = 0;

  octree_node_address_unit_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_level(a_level),
    .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_level(b_level),
    .child_octant(child_octant),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_x(res_x), .res_y(res_y), .res_z(res_z), .res_level(res_level),
    .octant_out(octant_out), .octant_valid(octant_valid),
    .flag(flag), .error(error)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor. All node arithmetic is done on 64-bit signed values so that node
  // ends such as 32767 + 2^15 and parents at level 16 never overflow.
  // ---------------------------------------------------------------------------

  // Clears the low bits, which floors toward minus infinity in two's complement.
  function automatic longint floor_to(longint c, int lv);
    return c & ~((longint'(1) << lv) - 1);
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic int bit_length(longint v);
    int n;
    n = 0;
    while (n < 63 && (v >> n) != 0) n++;
    return n;
  endfunction

  // True when node n lies inside node o on every axis, shared faces included.
  function automatic bit encloses(longint o [AXES], int olv, longint n [AXES], int nlv);
    for (int i = 0; i < AXES; i++) begin
      if (n[i] < o[i] || n[i] + (longint'(1) << nlv) > o[i] + (longint'(1) << olv))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic node_answer_t compute_node_answer(node_query_t q);
    node_answer_t r;
    longint na [AXES];
    longint nb [AXES];
    longint rc [AXES];
    longint lo, hi, mid, bhi, span;
    int la, lb, rl, lv;
    bit err, has_node, whole, found, answer;
    logic [OCT_W-1:0] oct;
    la = q.a_level;
    lb = q.b_level;
    rl = 0;
    err = 1'b0;
    has_node = 1'b0;
    whole = 1'b0;
    answer = 1'b0;
    oct = '0;
    for (int i = 0; i < AXES; i++) begin
      na[i] = q.a[i];
      nb[i] = q.b[i];
      rc[i] = 0;
    end
    case (q.command)
      CMD_PARENT: begin
        if (la >= MAX_LEVEL) begin
          err = 1'b1;
        end else begin
          for (int i = 0; i < AXES; i++) rc[i] = floor_to(na[i], la + 1);
          rl = la + 1;
          has_node = 1'b1;
        end
      end
      CMD_CHILD: begin
        if (la == 0) begin
          err = 1'b1;
        end else begin
          // The sum may leave the coordinate range; it wraps when truncated below.
          for (int i = 0; i < AXES; i++)
            rc[i] = na[i] + (q.octant[i] ? (longint'(1) << (la - 1)) : 0);
          rl = la - 1;
          has_node = 1'b1;
        end
      end
      CMD_OCTANT: begin
        if (!encloses(na, la, nb, lb)) begin
          err = 1'b1;
        end else if (la != 0) begin
          whole = 1'b1;
          for (int i = 0; i < AXES; i++) begin
            hi = na[i] + (longint'(1) << la);
            mid = hi / 2 + na[i] / 2;  // each half truncates toward zero
            bhi = nb[i] + (longint'(1) << lb);
            if (sign_of(nb[i] - mid) + sign_of(bhi - mid) == 0) whole = 1'b0;
            if (bhi > mid) oct[i] = 1'b1;
          end
          if (!whole) oct = '0;
        end
      end
      CMD_ROOT: begin
        span = 0;
        lv = la + 1;
        for (int i = 0; i < AXES; i++) begin
          lo = floor_to(na[i], lv);
          hi = lo + (longint'(1) << lv);
          if (magnitude(lo) > span) span = magnitude(lo);
          if (magnitude(hi) > span) span = magnitude(hi);
        end
        rl = 1 + bit_length(span - 1);
        if (rl > MAX_LEVEL || rl > COORD_BITS) begin
          err = 1'b1;
        end else begin
          for (int i = 0; i < AXES; i++) rc[i] = -(longint'(1) << (rl - 1));
          has_node = 1'b1;
        end
      end
      CMD_CONTAINER: begin
        for (int i = 0; i < AXES; i++)
          if ((na[i] >= 0) != (nb[i] >= 0)) err = 1'b1;
        if (!err) begin
          if (encloses(na, la, nb, lb)) begin
            rc = na;
            rl = la;
          end else if (encloses(nb, lb, na, la)) begin
            rc = nb;
            rl = lb;
          end else begin
            // Flooring a straight to each coarser level gives its ancestor chain.
            found = 1'b0;
            for (lv = la + 1; lv <= MAX_LEVEL && !found; lv++) begin
              for (int i = 0; i < AXES; i++) rc[i] = floor_to(na[i], lv);
              if (encloses(rc, lv, nb, lb)) begin
                found = 1'b1;
                rl = lv;
              end
            end
            if (!found) err = 1'b1;
          end
          has_node = !err;
        end
      end
      CMD_CONTAINS: begin
        answer = encloses(na, la, nb, lb);
      end
      CMD_IS_ROOT: begin
        answer = 1'b1;
        for (int i = 0; i < AXES; i++) begin
          lo = na[i];
          hi = lo + (longint'(1) << la);
          if (magnitude(lo) != magnitude(hi)) answer = 1'b0;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase
    if (err || !has_node) begin
      for (int i = 0; i < AXES; i++) rc[i] = 0;
      rl = 0;
    end
    if (err) begin
      whole = 1'b0;
      oct = '0;
      answer = 1'b0;
    end
    for (int i = 0; i < AXES; i++) r.pos[i] = COORD_BITS'(rc[i]);
    r.level = LEVEL_W'(rl);
    r.octant = oct;
    r.octant_ok = whole;
    r.flag = answer;
    r.error = err;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  task automatic queue_query(input logic [CMD_W-1:0] cmd, input int ax, input int ay,
                             input int az, input int al, input int bx, input int by,
                             input int bz, input int bl, input int oct);
    node_query_t q;
    q.command = cmd;
    q.a[0] = COORD_BITS'(ax);
    q.a[1] = COORD_BITS'(ay);
    q.a[2] = COORD_BITS'(az);
    q.a_level = LEVEL_W'(al);
    q.b[0] = COORD_BITS'(bx);
    q.b[1] = COORD_BITS'(by);
    q.b[2] = COORD_BITS'(bz);
    q.b_level = LEVEL_W'(bl);
    q.octant = OCT_W'(oct);
    query_q.push_back(q);
  endtask

  // A random corner aligned to 2^lv; half the time shrunk toward zero so that small
  // magnitudes show up as often as large ones.
  function automatic logic signed [COORD_BITS-1:0] corner_at(int lv);
    logic signed [COORD_BITS-1:0] v;
    v = COORD_BITS'($urandom);
    if ($urandom_range(0, 1) == 1) v = v >>> $urandom_range(0, COORD_BITS - 1);
    return COORD_BITS'(v & ~((1 << lv) - 1));
  endfunction

  // Mostly well-formed queries: aligned nodes, b nested in a, centred cubes for the
  // root test, same-sign pairs for the container. About one in ten is pure noise.
  function automatic node_query_t random_query();
    node_query_t q;
    logic signed [COORD_BITS-1:0] hold [AXES];
    logic [LEVEL_W-1:0] hold_level;
    int la, lb, pick, axis;
    la = $urandom_range(0, MAX_LEVEL);
    lb = $urandom_range(0, la);
    pick = $urandom_range(0, 9);
    q.command = CMD_W'($urandom_range(CMD_PARENT, CMD_IS_ROOT));
    q.a_level = LEVEL_W'(la);
    q.b_level = LEVEL_W'(lb);
    q.octant = OCT_W'($urandom);
    for (int i = 0; i < AXES; i++) begin
      q.a[i] = corner_at(la);
      q.b[i] = COORD_BITS'(q.a[i] + (corner_at(lb) & ((1 << la) - 1)));
    end
    case (q.command)
      CMD_OCTANT, CMD_CONTAINS: begin
        if (pick == 9) begin
          q.b = q.a;
          q.b_level = q.a_level;
        end else if (pick >= 7) begin
          for (int i = 0; i < AXES; i++) q.b[i] = corner_at(lb);
        end else if (pick >= 5) begin
          // Inside a but off the grid of its own size.
          for (int i = 0; i < AXES; i++)
            q.b[i] = COORD_BITS'(q.a[i] + $urandom_range(0, (1 << la) - (1 << lb)));
        end
      end
      CMD_CONTAINER: begin
        if (pick >= 6) begin
          q.b_level = LEVEL_W'($urandom);
          for (int i = 0; i < AXES; i++) begin
            q.b[i] = corner_at(q.b_level);
            if (pick < 9) q.b[i][COORD_BITS-1] = q.a[i][COORD_BITS-1];
          end
        end else if (pick >= 3) begin
          hold = q.a;
          hold_level = q.a_level;
          q.a = q.b;
          q.a_level = q.b_level;
          q.b = hold;
          q.b_level = hold_level;
        end
      end
      CMD_ROOT: begin
        for (int i = 0; i < AXES; i++)
          q.a[i] = corner_at(0) >>> $urandom_range(0, COORD_BITS - 1);
      end
      CMD_IS_ROOT: begin
        if (pick < 6) begin
          la = $urandom_range(1, MAX_LEVEL);
          q.a_level = LEVEL_W'(la);
          for (int i = 0; i < AXES; i++) q.a[i] = COORD_BITS'(-(1 << (la - 1)));
          if (pick == 5) begin
            axis = $urandom_range(0, AXES - 1);
            q.a[axis] = COORD_BITS'(q.a[axis] + (1 << $urandom_range(0, la)));
          end
        end
      end
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      q.command = CMD_W'($urandom);
      for (int i = 0; i < AXES; i++) begin
        q.a[i] = COORD_BITS'($urandom);
        q.b[i] = COORD_BITS'($urandom);
      end
      q.a_level = LEVEL_W'($urandom);
      q.b_level = LEVEL_W'($urandom);
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers items in bursts of random length separated by random gaps.
  // A new item is placed on the ports only after the current one was accepted, so
  // a stalled payload never changes and valid never looks at stall.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : sender
    node_query_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (query_q.size() != 0) begin
        item = query_q.pop_front();
        command <= item.command;
        a_x <= item.a[0];
        a_y <= item.a[1];
        a_z <= item.a[2];
        a_level <= item.a_level;
        b_x <= item.b[0];
        b_y <= item.b[1];
        b_z <= item.b[2];
        b_level <= item.b_level;
        child_octant <= item.octant;
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // Back-to-back bursts are common so that long stretches run without gaps.
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: the stall pattern switches now and then between no stall, random
  // stalls, a short periodic pattern and long holds that fill the pipeline.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : receiver
    if (stall_tick == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_tick = $urandom_range(20, 80);
    end else begin
      stall_tick--;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: out_stall <= (stall_tick % 5 < 3);
      default:        out_stall <= (stall_tick % 24 < 16);
    endcase
  end

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, an accepted result is checked against the oldest
  // expectation, and an accepted input item adds its predicted result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    node_query_t seen;
    node_answer_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          $error("result item arrived with no query outstanding");
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          check_field("res_x", want.pos[0], res_x);
          check_field("res_y", want.pos[1], res_y);
          check_field("res_z", want.pos[2], res_z);
          check_field("res_level", want.level, res_level);
          check_field("octant_out", want.octant, octant_out);
          check_field("octant_valid", want.octant_ok, octant_valid);
          check_field("flag", want.flag, flag);
          check_field("error", want.error, error);
        end
      end
      if (in_valid && !in_stall) begin
        seen.command = command;
        seen.a[0] = a_x;
        seen.a[1] = a_y;
        seen.a[2] = a_z;
        seen.a_level = a_level;
        seen.b[0] = b_x;
        seen.b[1] = b_y;
        seen.b[2] = b_z;
        seen.b_level = b_level;
        seen.octant = child_octant;
        answer_q.push_back(compute_node_answer(seen));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence: directed corner cases, then random queries, then drain.
  // ---------------------------------------------------------------------------
  initial begin
    // Parent: both coordinate extremes, the deepest legal level and one past it.
    queue_query(CMD_PARENT, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0);
    queue_query(CMD_PARENT, 32767, -1, 12345, 14, 0, 0, 0, 0, 0);
    queue_query(CMD_PARENT, 100, -100, 7, 15, 0, 0, 0, 0, 0);
    // Child: a leaf has none, a sum past the top wraps, and a mixed octant.
    queue_query(CMD_CHILD, 5, 6, 7, 0, 0, 0, 0, 0, 7);
    queue_query(CMD_CHILD, 32767, 32767, 32767, 15, 0, 0, 0, 0, 7);
    queue_query(CMD_CHILD, -32768, -32768, -32768, 1, 0, 0, 0, 0, 0);
    queue_query(CMD_CHILD, -64, 32, 0, 5, 0, 0, 0, 0, 5);
    // Octant: one octant, a node straddling the mid planes, a leaf, b outside a,
    // unaligned corners with midpoints rounded toward zero, and the full range.
    queue_query(CMD_OCTANT, 0, 0, 0, 4, 8, 0, 4, 1, 0);
    queue_query(CMD_OCTANT, -16, -16, -16, 4, -16, -16, -16, 4, 0);
    queue_query(CMD_OCTANT, 9, 9, 9, 0, 9, 9, 9, 0, 0);
    queue_query(CMD_OCTANT, 0, 0, 0, 3, 8, 0, 0, 0, 0);
    queue_query(CMD_OCTANT, -7, -7, -7, 3, -7, -3, 0, 0, 0);
    queue_query(CMD_OCTANT, -32768, -32768, -32768, 15, -16384, -32768, -32768, 14, 0);
    // Root: the smallest case, one too large for the level range, and a mixed one.
    queue_query(CMD_ROOT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_query(CMD_ROOT, -32768, 0, 0, 14, 0, 0, 0, 0, 0);
    queue_query(CMD_ROOT, 1000, -3000, 200, 3, 0, 0, 0, 0, 0);
    // Container: opposite signs, a holds b, b holds a, siblings, and no ancestor.
    queue_query(CMD_CONTAINER, 5, -5, 5, 0, 5, 5, 5, 0, 0);
    queue_query(CMD_CONTAINER, 0, 0, 0, 4, 2, 4, 6, 1, 0);
    queue_query(CMD_CONTAINER, 2, 4, 6, 1, 0, 0, 0, 4, 0);
    queue_query(CMD_CONTAINER, 0, 0, 0, 2, 4, 0, 0, 2, 0);
    queue_query(CMD_CONTAINER, 32767, 1, 1, 15, 100, 1, 1, 0, 0);
    // Contains and is-root, each answered both ways.
    queue_query(CMD_CONTAINS, -32768, -32768, -32768, 15, 32767, 32767, 32767, 0, 0);
    queue_query(CMD_CONTAINS, 0, 0, 0, 15, 32767, 32767, 32767, 0, 0);
    queue_query(CMD_IS_ROOT, -4, -4, -4, 3, 0, 0, 0, 0, 0);
    queue_query(CMD_IS_ROOT, -4, -4, 0, 3, 0, 0, 0, 0, 0);
    // The unused command encoding, with every other field at all ones.
    queue_query(CMD_UNDEFINED, -1, -1, -1, 15, -1, -1, -1, 15, 7);
    repeat (600) query_q.push_back(random_query());

    wait (!rst);
    // Once nothing is pending and valid is low at a rising edge, every item was taken.
    do @(posedge clk); while (query_q.size() != 0 || in_valid);
    while (answer_q.size() != 0) @(posedge clk);
    // A few more cycles catch any extra result still coming out of the pipeline.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of this item count.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/onau_pkg.sv
src/octree_node_address_unit_top.sv
tb/octree_node_address_unit_top_tb.sv
